// ===== rtl/core/afb_pkg.sv =====
// package for the addressed frame builder with 16-bit additive checksum
// holds byte roles, item codes and the structs passed between the core modules
// no dependencies
package afb_pkg;

    localparam int unsigned MAX_RESULTS = 5;
    localparam int unsigned IDX_W       = $clog2(MAX_RESULTS);

    localparam logic [15:0] LOW_BYTE_MASK = 16'h00FF;

    localparam logic FUNC_HEADER  = 1'b0;
    localparam logic FUNC_PAYLOAD = 1'b1;

    typedef enum logic [2:0] {
        ROLE_ADDR = 3'd0,
        ROLE_TYPE = 3'd1,
        ROLE_LEN  = 3'd2,
        ROLE_DATA = 3'd3,
        ROLE_CKHI = 3'd4,
        ROLE_CKLO = 3'd5
    } t_role;

    typedef struct packed {
        logic [7:0] data;
        t_role      role;
    } t_entry;

    // bytes caused by one input item, entry 0 goes out first
    typedef struct packed {
        t_entry [MAX_RESULTS-1:0] entry;
        logic   [IDX_W:0]         count;
    } t_list;

    // one outgoing byte with its flags
    typedef struct packed {
        logic [7:0] data;
        t_role      role;
        logic       drive;
        logic       fend;
        logic       last;
    } t_beat;

endpackage

// ===== rtl/core/afb_frame_ctl.sv =====
// frame state and byte list builder for the addressed frame builder
// keeps payload count, running sum and open flag; depends on afb_pkg
module afb_frame_ctl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic           i_func,
    input  logic [7:0]     i_dest_addr,
    input  logic [7:0]     i_kind_code,
    input  logic [7:0]     i_payload_len,
    input  logic [7:0]     i_payload_byte,
    output afb_pkg::t_list o_list
);
    import afb_pkg::*;

    logic [7:0]  r_left, n_left;
    logic [15:0] r_sum,  n_sum;
    logic        r_open, n_open;

    logic [15:0] hdr_sum;
    logic [15:0] pay_sum;
    t_list       list;

    assign hdr_sum = 16'(i_dest_addr) + 16'(i_kind_code) + 16'(i_payload_len);
    assign pay_sum = r_sum + 16'(i_payload_byte);

    always_comb begin
        n_left = r_left;
        n_sum  = r_sum;
        n_open = r_open;
        list   = '0;
        if (i_func == FUNC_HEADER) begin
            n_sum            = hdr_sum;
            list.entry[0]    = '{data: i_dest_addr,   role: ROLE_ADDR};
            list.entry[1]    = '{data: i_kind_code,   role: ROLE_TYPE};
            list.entry[2]    = '{data: i_payload_len, role: ROLE_LEN};
            if (i_payload_len == 8'd0) begin
                // empty payload: checksum follows the header at once
                list.entry[3] = '{data: hdr_sum[15:8], role: ROLE_CKHI};
                list.entry[4] = '{data: 8'(hdr_sum & LOW_BYTE_MASK), role: ROLE_CKLO};
                list.count    = (IDX_W+1)'(5);
                n_left        = 8'd0;
                n_open        = 1'b0;
            end else begin
                list.count    = (IDX_W+1)'(3);
                n_left        = i_payload_len;
                n_open        = 1'b1;
            end
        end else begin
            if (!r_open || r_left == 8'd0) begin
                // stray payload byte, dropped
                n_open = 1'b0;
            end else begin
                n_sum         = pay_sum;
                n_left        = r_left - 8'd1;
                list.entry[0] = '{data: i_payload_byte, role: ROLE_DATA};
                if (r_left == 8'd1) begin
                    list.entry[1] = '{data: pay_sum[15:8], role: ROLE_CKHI};
                    list.entry[2] = '{data: 8'(pay_sum & LOW_BYTE_MASK), role: ROLE_CKLO};
                    list.count    = (IDX_W+1)'(3);
                    n_open        = 1'b0;
                end else begin
                    list.count    = (IDX_W+1)'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 8'd0;
            r_sum  <= 16'd0;
            r_open <= 1'b0;
        end else if (i_accept) begin
            r_left <= n_left;
            r_sum  <= n_sum;
            r_open <= n_open;
        end
    end

    assign o_list = list;

endmodule

// ===== rtl/core/afb_out_seq.sv =====
// output sequencer for the addressed frame builder
// holds one item's byte list and hands it out a byte per cycle through the
// output register while the byte side does not stall; depends on afb_pkg
module afb_out_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  afb_pkg::t_list i_list,
    output logic           o_free,
    output logic           o_valid,
    input  logic           i_ready,
    output afb_pkg::t_beat o_beat
);
    import afb_pkg::*;

    t_entry [MAX_RESULTS-1:0] r_list;
    logic   [IDX_W:0]         r_cnt;
    logic   [IDX_W-1:0]       r_idx;
    logic                     r_out_valid;
    t_beat                    r_out;

    logic   has_entry;
    logic   out_load;
    logic   advance;
    logic   last_entry;
    t_entry cur;

    assign has_entry  = (r_cnt != '0);
    assign out_load   = !r_out_valid || i_ready;
    assign advance    = has_entry && out_load;
    assign last_entry = ((IDX_W+1)'(r_idx) == r_cnt - (IDX_W+1)'(1));
    assign cur        = r_list[r_idx];

    // a new list may come in while the last byte of the old one moves out
    assign o_free = !has_entry || (advance && last_entry);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (i_load) begin
            r_cnt <= i_list.count;
            r_idx <= '0;
        end else if (advance) begin
            if (last_entry) begin
                r_cnt <= '0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_list <= i_list.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= advance;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.data  <= cur.data;
            r_out.role  <= cur.role;
            r_out.drive <= (cur.role != ROLE_CKLO);
            r_out.fend  <= (cur.role == ROLE_CKLO);
            r_out.last  <= last_entry;
        end
    end

    assign o_valid = r_out_valid;
    assign o_beat  = r_out;

endmodule

// ===== rtl/core/addressed_frame_builder_sum16.sv =====
// top level of the addressed frame builder with 16-bit additive checksum
// joins the frame state unit and the output sequencer; depends on afb_pkg,
// afb_frame_ctl and afb_out_seq
//
//  channel   dir  tdata                      tuser                          tlast
//  s (items) in   addr, type, len, payload   func (0 header, 1 payload)     -
//  m (bytes) out  byte to send               role, drive enable, frame end  last byte of item
//
// a payload item gives one byte, a header three bytes (five with an empty
// payload) and the last payload item three, sent through the single output
// register that moves one byte per cycle while the byte side does not stall
// first byte of an item is registered in the byte list, then in the output register
// synchronous active-low reset empties the byte list and output register and
// clears the frame state (no frame open, sum zero)
// a stall on the byte side holds the output register and the byte list; the
// item side waits while the list still holds a byte that has not moved out
module addressed_frame_builder_sum16 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // dest_addr[7:0], kind_code[15:8],
                                     // payload_len[23:16], payload_byte[31:24]
    input  logic        i_s_tuser,   // func[0]
    // byte side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // tx_byte[7:0]
    output logic [4:0]  o_m_tuser,   // byte_role[2:0], drive_enable[3], frame_end[4]
    output logic        o_m_tlast    // run_last
);
    import afb_pkg::*;

    logic  s_accept;
    logic  seq_free;
    t_list list;
    t_beat beat;

    // item transfer when the sequencer can take a fresh byte list
    assign o_s_tready = seq_free;
    assign s_accept   = i_s_tvalid && seq_free;

    afb_frame_ctl u_frame_ctl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (s_accept),
        .i_func         (i_s_tuser),
        .i_dest_addr    (i_s_tdata[7:0]),
        .i_kind_code    (i_s_tdata[15:8]),
        .i_payload_len  (i_s_tdata[23:16]),
        .i_payload_byte (i_s_tdata[31:24]),
        .o_list         (list)
    );

    // a dropped payload item loads an empty list, which gives no bytes
    afb_out_seq u_out_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (s_accept),
        .i_list  (list),
        .o_free  (seq_free),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_beat  (beat)
    );

    // byte side packing
    assign o_m_tdata = beat.data;
    assign o_m_tuser = {beat.fend, beat.drive, beat.role};
    assign o_m_tlast = beat.last;

endmodule

// ===== verif/frame_byte_checker.sv =====
`timescale 1ns / 100ps
// byte checker for addressed_frame_builder_sum16: predicts the bytes of every item transfer
// and compares them in order with the transfers on the byte side; depends on afb_pkg
module frame_byte_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,   // dest_addr[7:0], kind_code[15:8],
                                     // payload_len[23:16], payload_byte[31:24]
    input  logic        i_s_tuser,   // func[0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,   // tx_byte[7:0]
    input  logic [4:0]  i_m_tuser,   // byte_role[2:0], drive_enable[3], frame_end[4]
    input  logic        i_m_tlast,   // run_last
    output int          o_fail_count,
    output int          o_bytes_pending
);
    import afb_pkg::*;

    t_beat       expected_bytes[$];
    logic [7:0]  payload_left;
    logic [15:0] frame_sum;
    logic        frame_open;
    int          mismatches;

    task automatic queue_byte(input logic [7:0] data, input t_role role,
                              input logic drive, input logic fend);
        t_beat b;
        b.data  = data;
        b.role  = role;
        b.drive = drive;
        b.fend  = fend;
        b.last  = 1'b0;
        expected_bytes.push_back(b);
    endtask

    // checksum high then low, drive enable off for the low byte, which ends the frame
    task automatic queue_checksum();
        queue_byte(frame_sum[15:8], ROLE_CKHI, 1'b1, 1'b0);
        queue_byte(frame_sum[7:0], ROLE_CKLO, 1'b0, 1'b1);
        frame_open   = 1'b0;
        payload_left = 8'd0;
    endtask

    task automatic build_frame_bytes(input logic func, input logic [31:0] item);
        logic [7:0] addr;
        logic [7:0] kind;
        logic [7:0] len;
        logic [7:0] pay;
        int         first;
        t_beat      tail;
        addr  = item[7:0];
        kind  = item[15:8];
        len   = item[23:16];
        pay   = item[31:24];
        first = expected_bytes.size();
        if (func == FUNC_HEADER) begin
            frame_sum = {8'h00, addr} + {8'h00, kind} + {8'h00, len};
            queue_byte(addr, ROLE_ADDR, 1'b1, 1'b0);
            queue_byte(kind, ROLE_TYPE, 1'b1, 1'b0);
            queue_byte(len, ROLE_LEN, 1'b1, 1'b0);
            if (len == 8'd0) begin
                queue_checksum();
            end else begin
                payload_left = len;
                frame_open   = 1'b1;
            end
        end else if (frame_open && payload_left != 8'd0) begin
            frame_sum = frame_sum + {8'h00, pay};
            queue_byte(pay, ROLE_DATA, 1'b1, 1'b0);
            payload_left = payload_left - 8'd1;
            if (payload_left == 8'd0)
                queue_checksum();
        end else begin
            frame_open = 1'b0;
        end
        // mark the final byte of this item
        if (expected_bytes.size() > first) begin
            tail      = expected_bytes.pop_back();
            tail.last = 1'b1;
            expected_bytes.push_back(tail);
        end
    endtask

    task automatic check_byte();
        t_beat got;
        t_beat want;
        got.data  = i_m_tdata;
        got.role  = t_role'(i_m_tuser[2:0]);
        got.drive = i_m_tuser[3];
        got.fend  = i_m_tuser[4];
        got.last  = i_m_tlast;
        if (expected_bytes.size() == 0) begin
            if (mismatches < 10)
                $display("%0t: unexpected byte %h role %0d drive %b end %b last %b",
                         $time, got.data, got.role, got.drive, got.fend, got.last);
            mismatches++;
        end else begin
            want = expected_bytes.pop_front();
            if (got.data !== want.data || got.role !== want.role ||
                    got.drive !== want.drive || got.fend !== want.fend ||
                    got.last !== want.last) begin
                if (mismatches < 10) begin
                    $write("%0t: expected byte %h role %0d drive %b end %b last %b,",
                           $time, want.data, want.role, want.drive, want.fend, want.last);
                    $display(" got byte %h role %0d drive %b end %b last %b",
                             got.data, got.role, got.drive, got.fend, got.last);
                end
                mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_bytes.delete();
            payload_left = 8'd0;
            frame_sum    = 16'd0;
            frame_open   = 1'b0;
            mismatches   = 0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                build_frame_bytes(i_s_tuser, i_s_tdata);
            if (i_m_tvalid && i_m_tready)
                check_byte();
        end
        o_fail_count    <= mismatches;
        o_bytes_pending <= expected_bytes.size();
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// top of the frame builder testbench: clock, reset, item stimulus and byte-side back-pressure
// depends on afb_pkg, addressed_frame_builder_sum16 and frame_byte_checker
module testbench;
    import afb_pkg::*;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = 32'd0;   // dest_addr, kind_code, payload_len, payload_byte
    logic        s_tuser  = 1'b0;    // func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;            // tx_byte
    logic [4:0]  m_tuser;            // byte_role, drive_enable, frame_end
    logic        m_tlast;
    int          fail_count;
    int          bytes_pending;

    // percentage of cycles in which the item side idles or the byte side stalls
    int          idle_pct  = 0;
    int          stall_pct = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    addressed_frame_builder_sum16 uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    frame_byte_checker u_byte_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_tvalid      (s_tvalid),
        .i_s_tready      (s_tready),
        .i_s_tdata       (s_tdata),
        .i_s_tuser       (s_tuser),
        .i_m_tvalid      (m_tvalid),
        .i_m_tready      (m_tready),
        .i_m_tdata       (m_tdata),
        .i_m_tuser       (m_tuser),
        .i_m_tlast       (m_tlast),
        .o_fail_count    (fail_count),
        .o_bytes_pending (bytes_pending)
    );

    // byte side back-pressure, a fresh draw every cycle
    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // one item transfer, preceded by a random run of idle cycles
    task automatic send_item(input logic func, input logic [7:0] addr, input logic [7:0] kind,
                             input logic [7:0] len, input logic [7:0] pay);
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pay, len, kind, addr};
        s_tuser  <= func;
        // hold until the transfer has taken place
        do @(posedge clk); while (!s_tready);
    endtask

    // fields a header does not use still carry random bits
    task automatic send_header(input logic [7:0] addr, input logic [7:0] kind,
                               input logic [7:0] len);
        send_item(FUNC_HEADER, addr, kind, len, 8'($urandom_range(255)));
    endtask

    task automatic send_payload(input logic [7:0] pay);
        send_item(FUNC_PAYLOAD, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), pay);
    endtask

    // mostly well-formed frames with random content; some stray payload bytes between
    // frames and the odd frame cut short, so that the next header abandons it
    task automatic run_random_phase(input int target);
        int counted;
        int len;
        int cut;
        int k;
        counted = 0;
        while (counted < target) begin
            if ($urandom_range(99) < 12) begin
                send_payload(8'($urandom_range(255)));
            end else begin
                if ($urandom_range(99) < 10)
                    len = $urandom_range(40, 6);
                else
                    len = $urandom_range(5, 0);
                send_header(8'($urandom_range(255)), 8'($urandom_range(255)), 8'(len));
                counted++;
                cut = ($urandom_range(9) == 0) ? $urandom_range(len, 0) : len;
                for (k = 0; k < cut; k++) begin
                    send_payload(8'($urandom_range(255)));
                    counted++;
                end
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed part, no idling
        send_payload(8'hFF);                  // no frame open yet, ignored
        send_header(8'h00, 8'h00, 8'h00);     // empty payload, checksum straight after header
        send_header(8'hFF, 8'hFF, 8'h00);
        send_header(8'hA5, 8'h5A, 8'h01);     // single payload byte closes the frame
        send_payload(8'hFF);
        send_header(8'h12, 8'h34, 8'h03);     // frame abandoned by the next header
        send_payload(8'h00);
        send_payload(8'h80);
        send_header(8'hFF, 8'h01, 8'h02);
        send_payload(8'h7F);
        send_payload(8'hFF);
        send_payload(8'h55);                  // frame already closed, ignored
        send_header(8'hFF, 8'hFF, 8'hFF);     // longest payload count, then cut short
        send_payload(8'hFF);
        send_payload(8'h01);
        send_header(8'h00, 8'h00, 8'h00);
        send_header(8'h01, 8'h02, 8'h01);
        send_payload(8'h00);

        run_random_phase(20);

        // longer frame of 0xff bytes, the sum carries well into the high byte
        send_header(8'hFF, 8'hFF, 8'd16);
        repeat (16) send_payload(8'hFF);

        // sender idling
        idle_pct  = 66;
        stall_pct = 0;
        run_random_phase(20);

        // receiver stalling
        idle_pct  = 0;
        stall_pct = 66;
        run_random_phase(20);

        // both sides
        idle_pct  = 27;
        stall_pct = 27;
        run_random_phase(20);

        s_tvalid <= 1'b0;
        // let the checker see the last transfer before draining
        @(posedge clk);
        while (bytes_pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        if (fail_count == 0 && bytes_pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule
